// ===== hw/rtl/sprite_table_physics_step_macros.svh =====
// assertion macros shared by the sprite table rtl
`ifndef SPRITE_TABLE_PHYSICS_STEP_MACROS_SVH
`define SPRITE_TABLE_PHYSICS_STEP_MACROS_SVH

// same-cycle implication, checked out of reset
`define STPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stps: same-cycle check failed");

// next-cycle implication, checked out of reset
`define STPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stps: next-cycle check failed");

`endif

// ===== hw/rtl/stps_pkg.sv =====
// types, codes and helper functions of the sprite table
package stps_pkg;

    localparam logic [2:0] OP_CREATE     = 3'd0;
    localparam logic [2:0] OP_SET_SPRITE = 3'd1;
    localparam logic [2:0] OP_SET_MOTION = 3'd2;
    localparam logic [2:0] OP_MOVE       = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    localparam int MAX_RESULTS = 64;
    localparam int NW          = 7;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         slot;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic               solid;
        logic [7:0]         frames;
        logic [15:0]        frame_period;
        logic signed [23:0] gravity;
        logic [15:0]        tick_dt;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         out_slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [7:0]         frame;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [15:0]        width_q;
        logic [15:0]        height_q;
        logic signed [23:0] x_vel;
        logic signed [23:0] y_vel;
        logic signed [23:0] grav;
        logic [7:0]         frame_now;
        logic [7:0]         frame_count;
        logic [15:0]        frame_clock;
        logic [15:0]        frame_len;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_TSCAN, S_LOAD, S_MULG, S_ADDG, S_MULX, S_MULY,
        S_MOVCHK, S_MVX, S_SWEEP, S_ANIM, S_WB, S_EMIT, S_FLUSH
    } t_state;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'h7F_FFFF;
        end else if (v < -32'sd8388608) begin
            return 24'h80_0000;
        end
        return v[23:0];
    endfunction

endpackage

// ===== hw/rtl/stps_ram.sv =====
// generic single-write, single-read ram with registered read data
module stps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sprite_table_physics_step.sv =====
// sprite slot table with axis-separated box collision movement
// create searches for a free slot; set_sprite, set_motion and move load, update and write back the slot
// tick scans every slot, updates each active slot and sweeps the table for each moving slot
// the single ram read port sets the rate: every collision sweep reads one slot per cycle
// results leave through a one-word output register and a one-word pending stage
// reset clears the sequencer, the active and solid bits and the output valid; slot ram is not cleared
`include "sprite_table_physics_step_macros.svh"

module sprite_table_physics_step
    import stps_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // sequencer and working copy of the slot under work
    t_state             r_state, n_state;
    t_in                r_in, n_in;
    t_rec               r_rec, n_rec;
    logic signed [31:0] r_old, n_old;     // axis value to restore on a hit
    logic signed [31:0] r_dx, n_dx;
    logic signed [31:0] r_dy, n_dy;
    logic               r_hit, n_hit;
    logic               r_axis, n_axis;   // 0 while sweeping x, 1 for y
    logic signed [40:0] r_prod, n_prod;   // shared multiplier output
    logic [IW-1:0]      r_cur, n_cur;
    logic [CW-1:0]      r_j, n_j;         // sweep and free-slot search counter
    logic               r_pv, n_pv;       // ram word of the sweep is valid
    logic [IW-1:0]      r_pj, n_pj;
    logic [CW-1:0]      r_i, n_i;         // tick scan counter
    logic [NW-1:0]      r_n, n_n;         // words reported in this tick
    t_out               r_res, n_res;     // pending word, last flag set only when it leaves in the flush
    logic               r_have, n_have;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [SLOTS-1:0]   r_active, n_active;
    logic [SLOTS-1:0]   r_blocks, n_blocks;

    // ram port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_rec               ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [$bits(t_rec)-1:0] ram_rdata;
    t_rec               rd;

    // shared multiplier operand
    logic signed [23:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [40:0] mul_p;

    stps_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd          = t_rec'(ram_rdata);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign mul_b       = $signed({1'b0, r_in.tick_dt});
    assign mul_p       = mul_a * mul_b;

    always_comb begin
        unique case (r_state)
            S_MULG:  mul_a = r_rec.grav;
            S_MULX:  mul_a = r_rec.x_vel;
            default: mul_a = r_rec.y_vel;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_active    <= '0;
            r_blocks    <= '0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_active    <= n_active;
            r_blocks    <= n_blocks;
        end
        r_in   <= n_in;
        r_rec  <= n_rec;
        r_old  <= n_old;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_hit  <= n_hit;
        r_axis <= n_axis;
        r_prod <= n_prod;
        r_cur  <= n_cur;
        r_j    <= n_j;
        r_pj   <= n_pj;
        r_i    <= n_i;
        r_n    <= n_n;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        logic               out_free;
        logic               in_range;
        logic [IW-1:0]      in_idx;
        logic               other;
        logic               overlap;
        logic signed [33:0] ax, ay, aw, ah, bx, by, bw, bh;
        logic [31:0]        vsum;
        logic [16:0]        csum;
        logic [15:0]        csat;
        logic [8:0]         fnext;
        t_out               res;

        n_state     = r_state;
        n_in        = r_in;
        n_rec       = r_rec;
        n_old       = r_old;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_hit       = r_hit;
        n_axis      = r_axis;
        n_prod      = r_prod;
        n_cur       = r_cur;
        n_j         = r_j;
        n_pv        = 1'b0;
        n_pj        = r_pj;
        n_i         = r_i;
        n_n         = r_n;
        n_res       = r_res;
        n_have      = r_have;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_active    = r_active;
        n_blocks    = r_blocks;
        ram_we      = 1'b0;
        ram_waddr   = r_cur;
        ram_wdata   = r_rec;
        ram_raddr   = r_cur;

        out_free = !r_out_valid || i_out_ready;
        in_range = (9'(i_in_data.slot) < 9'(SLOTS));
        in_idx   = IW'(i_in_data.slot);

        // strict box overlap of the slot under work against the swept word
        other = r_active[r_pj] && r_blocks[r_pj] && (r_pj != r_cur);
        ax = 34'(r_rec.x_pos);
        ay = 34'(r_rec.y_pos);
        aw = $signed({18'b0, r_rec.width_q});
        ah = $signed({18'b0, r_rec.height_q});
        bx = 34'(rd.x_pos);
        by = 34'(rd.y_pos);
        bw = $signed({18'b0, rd.width_q});
        bh = $signed({18'b0, rd.height_q});
        overlap = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);

        vsum  = '0;
        csum  = '0;
        csat  = '0;
        fnext = '0;

        res.status   = ST_OK;
        res.out_slot = 6'(r_cur);
        res.pos_x    = r_rec.x_pos;
        res.pos_y    = r_rec.y_pos;
        res.frame    = r_rec.frame_now;
        res.last     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = in_idx;
                if (i_in_valid) begin
                    n_in = i_in_data;
                    unique case (i_in_data.opcode)
                        OP_CREATE: begin
                            n_j     = '0;
                            n_state = S_FIND;
                        end
                        OP_SET_SPRITE, OP_SET_MOTION, OP_MOVE: begin
                            if (!in_range || !r_active[in_idx]) begin
                                n_res.status   = ST_INACTIVE;
                                n_res.out_slot = i_in_data.slot;
                                n_res.pos_x    = '0;
                                n_res.pos_y    = '0;
                                n_res.frame    = '0;
                                n_res.last     = 1'b0;
                                n_have         = 1'b1;
                                n_state        = S_FLUSH;
                            end else begin
                                n_cur   = in_idx;
                                n_state = S_LOAD;
                            end
                        end
                        OP_TICK: begin
                            n_i     = '0;
                            n_n     = '0;
                            n_state = S_TSCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                // first free slot, one slot a cycle
                if (r_j == CW'(SLOTS)) begin
                    n_res.status   = ST_FULL;
                    n_res.out_slot = '0;
                    n_res.pos_x    = '0;
                    n_res.pos_y    = '0;
                    n_res.frame    = '0;
                    n_res.last     = 1'b0;
                    n_have         = 1'b1;
                    n_state        = S_FLUSH;
                end else if (!r_active[r_j[IW-1:0]]) begin
                    ram_we                = 1'b1;
                    ram_waddr             = r_j[IW-1:0];
                    ram_wdata.x_pos       = r_in.arg_x;
                    ram_wdata.y_pos       = r_in.arg_y;
                    ram_wdata.width_q     = r_in.box_w;
                    ram_wdata.height_q    = r_in.box_h;
                    ram_wdata.x_vel       = '0;
                    ram_wdata.y_vel       = '0;
                    ram_wdata.grav        = '0;
                    ram_wdata.frame_now   = '0;
                    ram_wdata.frame_count = r_in.frames;
                    ram_wdata.frame_clock = '0;
                    ram_wdata.frame_len   = r_in.frame_period;
                    n_active[r_j[IW-1:0]] = 1'b1;
                    n_blocks[r_j[IW-1:0]] = r_in.solid;
                    n_res.status          = ST_OK;
                    n_res.out_slot        = 6'(r_j[IW-1:0]);
                    n_res.pos_x           = r_in.arg_x;
                    n_res.pos_y           = r_in.arg_y;
                    n_res.frame           = '0;
                    n_res.last            = 1'b0;
                    n_have                = 1'b1;
                    n_state               = S_FLUSH;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_TSCAN: begin
                ram_raddr = r_i[IW-1:0];
                if (r_i == CW'(SLOTS)) begin
                    n_state = S_FLUSH;
                end else if (r_active[r_i[IW-1:0]]) begin
                    n_cur   = r_i[IW-1:0];
                    n_state = S_LOAD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_LOAD: begin
                n_rec = rd;
                unique case (r_in.opcode)
                    OP_SET_SPRITE: begin
                        n_rec.frame_count = r_in.frames;
                        n_rec.frame_len   = r_in.frame_period;
                        n_rec.frame_now   = '0;
                        n_rec.frame_clock = '0;
                        n_state           = S_WB;
                    end
                    OP_SET_MOTION: begin
                        n_rec.x_vel = sat24(r_in.arg_x);
                        n_rec.y_vel = sat24(r_in.arg_y);
                        n_rec.grav  = r_in.gravity;
                        n_state     = S_WB;
                    end
                    OP_MOVE: begin
                        n_dx    = r_in.arg_x;
                        n_dy    = r_in.arg_y;
                        n_state = S_MVX;
                    end
                    default: begin
                        n_state = S_MULG;
                    end
                endcase
            end
            S_MULG: begin
                n_prod  = mul_p;
                n_state = S_ADDG;
            end
            S_ADDG: begin
                // only positive gravity pulls; floor shift of the product
                if (!r_rec.grav[23] && (r_rec.grav != '0)) begin
                    vsum = {{8{r_rec.y_vel[23]}}, r_rec.y_vel}
                         + {{7{r_prod[40]}}, r_prod[40:16]};
                    n_rec.y_vel = sat24($signed(vsum));
                end
                n_state = S_MULX;
            end
            S_MULX: begin
                n_prod  = mul_p;
                n_state = S_MULY;
            end
            S_MULY: begin
                n_dx    = {{7{r_prod[40]}}, r_prod[40:16]};
                n_prod  = mul_p;
                n_state = S_MOVCHK;
            end
            S_MOVCHK: begin
                n_dy = {{7{r_prod[40]}}, r_prod[40:16]};
                if ((r_rec.x_vel != '0) || (r_rec.y_vel != '0)) begin
                    n_state = S_MVX;
                end else begin
                    n_state = S_ANIM;
                end
            end
            S_MVX: begin
                n_old       = r_rec.x_pos;
                n_rec.x_pos = sat_add32(r_rec.x_pos, r_dx);
                n_axis      = 1'b0;
                n_j         = '0;
                n_hit       = 1'b0;
                n_state     = S_SWEEP;
            end
            S_SWEEP: begin
                // issue one read a cycle, compare the word in the cycle after its read
                ram_raddr = r_j[IW-1:0];
                if (r_pv && other && overlap) begin
                    n_hit = 1'b1;
                end
                if (r_j != CW'(SLOTS)) begin
                    n_pv = 1'b1;
                    n_pj = r_j[IW-1:0];
                    n_j  = r_j + 1'b1;
                end else if (!r_pv) begin
                    if (!r_axis) begin
                        if (r_hit) begin
                            n_rec.x_pos = r_old;
                        end
                        n_old       = r_rec.y_pos;
                        n_rec.y_pos = sat_add32(r_rec.y_pos, r_dy);
                        n_axis      = 1'b1;
                        n_j         = '0;
                        n_hit       = 1'b0;
                    end else begin
                        if (r_hit) begin
                            n_rec.y_pos = r_old;
                        end
                        n_state = (r_in.opcode == OP_TICK) ? S_ANIM : S_WB;
                    end
                end
            end
            S_ANIM: begin
                if (r_rec.frame_count > 8'd1) begin
                    csum = {1'b0, r_rec.frame_clock} + {1'b0, r_in.tick_dt};
                    csat = csum[16] ? 16'hFFFF : csum[15:0];
                    if (csat >= r_rec.frame_len) begin
                        fnext             = {1'b0, r_rec.frame_now} + 9'd1;
                        n_rec.frame_clock = '0;
                        n_rec.frame_now   = (fnext >= {1'b0, r_rec.frame_count}) ?
                                            8'd0 : fnext[7:0];
                    end else begin
                        n_rec.frame_clock = csat;
                    end
                end
                n_state = S_WB;
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = r_rec;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // the previous word leaves only once a later one exists
                if ((r_in.opcode == OP_TICK) && (r_n >= NW'(MAX_RESULTS))) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_TSCAN;
                end else if (!r_have || out_free) begin
                    if (r_have) begin
                        n_out       = r_res;
                        n_out.last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_res  = res;
                    n_have = 1'b1;
                    n_n    = r_n + 1'b1;
                    if (r_in.opcode == OP_TICK) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_TSCAN;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_have) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out       = r_res;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_have      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // no word may linger in the pending stage once the sequencer is idle
    `STPS_ASSERT_NOW(a_idle_drained, r_state == S_IDLE, !r_have)
    // an inactive-slot answer is always the only word of its item
    `STPS_ASSERT_NOW(a_inactive_last, o_out_valid && (r_out.status == ST_INACTIVE), r_out.last)
    // a create that found a free slot marks it active
    `STPS_ASSERT_NEXT(a_create_marks,
        (r_state == S_FIND) && (r_j != CW'(SLOTS)) && !r_active[r_j[IW-1:0]],
        r_active[$past(r_j[IW-1:0])])
    // the sweep counter never runs past the table
    `STPS_ASSERT_NOW(a_sweep_bound, r_state == S_SWEEP, r_j <= CW'(SLOTS))

endmodule
